// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define DUSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define DUSF_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `DUSF_ASSERT(lbl, clk, rst, !(cond), msg)

`else

`define DUSF_ASSERT(lbl, clk, rst, prop, msg)
`define DUSF_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/dusf_pkg.sv =====
package dusf_pkg;

   // Output port instances in the product; only the first ADDR_REGS can be addressed.
   localparam int NUM_OUTPUTS = 4;
   localparam int ADDR_REGS   = 4;
   localparam int PORTS_USED  = (NUM_OUTPUTS < ADDR_REGS) ? NUM_OUTPUTS : ADDR_REGS;
   localparam int SIDX_W      = (PORTS_USED > 1) ? $clog2(PORTS_USED) : 1;

   localparam int ADDR_W    = 15;
   localparam int SEQ_W     = 8;
   localparam int TICK_W    = 32;
   localparam int TMO_W     = 16;
   localparam int PCOUNT_W  = 3;
   localparam int PIDX_W    = 2;
   localparam int VERDICT_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);
   localparam logic [SEQ_W-1:0] SEQ_MAX       = SEQ_W'(255);
   localparam logic [SEQ_W-1:0] SEQ_HALF      = SEQ_W'(128);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PORT_COUNT = 3'd0,
      CSR_PORT0_ADDR = 3'd1,
      CSR_PORT1_ADDR = 3'd2,
      CSR_PORT2_ADDR = 3'd3,
      CSR_PORT3_ADDR = 3'd4,
      CSR_SYNC_MASK  = 3'd5,
      CSR_TIMEOUT    = 3'd6
   } csr_index_type;

   typedef enum logic [VERDICT_W-1:0] {
      V_INIT    = 3'd0,
      V_INORDER = 3'd1,
      V_SKIP    = 3'd2,
      V_RESYNC  = 3'd3,
      V_DROP    = 3'd4,
      V_SYNC    = 3'd5,
      V_NOPORT  = 3'd6
   } verdict_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic idle;        // request port open
      logic emit_port;   // load verdict of current port, update its state unless sync or drop
      logic advance;     // step to next port
      logic emit_noport; // load the no-port verdict
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic scan_end;    // port index past active ports
      logic hit;         // current port concerned by this request
      logic need_noport; // packet request and no port matched so far
      logic slot_free;   // output register can take a result this cycle
   } dp_status_type;

endpackage

// ===== rtl/dusf_req_if.sv =====
interface dusf_req_if import dusf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] packet_address;
   logic [SEQ_W-1:0]  packet_seq;
   logic              sync_flag;
   logic [TICK_W-1:0] now_tick;

   modport source (output valid, action, packet_address, packet_seq, sync_flag, now_tick,
                   input ready);
   modport sink   (input valid, action, packet_address, packet_seq, sync_flag, now_tick,
                   output ready);
endinterface

// ===== rtl/dusf_rsp_if.sv =====
interface dusf_rsp_if import dusf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIDX_W-1:0]    port;
   logic [VERDICT_W-1:0] verdict;
   logic                 deliver;

   modport source (output valid, port, verdict, deliver, input ready);
   modport sink   (input valid, port, verdict, deliver, output ready);
endinterface

// ===== rtl/dusf_csr_if.sv =====
interface dusf_csr_if import dusf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dusf_ctrl.sv =====
module dusf_ctrl import dusf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_end && (!status.need_noport || status.slot_free))
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               cmd.emit_noport = status.need_noport && status.slot_free;
            end else if (status.hit) begin
               cmd.emit_port = status.slot_free;
               cmd.advance   = status.slot_free;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/dusf_datapath.sv =====
`include "assert_macros.svh"

module dusf_datapath import dusf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   dusf_req_if.sink      req_chan,
   dusf_rsp_if.source    rsp_chan,
   dusf_csr_if.sink      csr_chan,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   // config
   logic [PCOUNT_W-1:0] port_count_ff;
   logic [ADDR_W-1:0]   port_addr_ff [ADDR_REGS];
   logic [ADDR_REGS-1:0] sync_mask_ff;
   logic [TMO_W-1:0]    timeout_ff;

   // latched request
   logic              act_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [TICK_W-1:0] now_ff;

   // scan
   logic [PCOUNT_W-1:0] pidx_ff;
   logic                found_ff;

   // per-port sequence state
   logic [SEQ_W-1:0]  stored_seq_ff [PORTS_USED];
   logic [TICK_W-1:0] last_tick_ff  [PORTS_USED];

   // output register
   logic                 rsp_valid_ff;
   logic [PIDX_W-1:0]    rsp_port_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;

   localparam logic [PCOUNT_W-1:0] PORTS_USED_C = PCOUNT_W'(PORTS_USED);

   logic                take_item;
   logic [PCOUNT_W-1:0] active;
   logic [PIDX_W-1:0]   psel;
   logic [SIDX_W-1:0]   sidx;
   logic [SEQ_W-1:0]    cur_seq;
   logic [SEQ_W-1:0]    next_seq;
   logic [SEQ_W-1:0]    seq_diff;
   logic [SEQ_W-1:0]    new_seq;
   logic [TICK_W:0]     tick_diff;
   logic                timed_out;
   verdict_type         pkt_verdict;
   verdict_type         cur_verdict;
   logic                load;

   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= '0;
         for (int i = 0; i < ADDR_REGS; i++) port_addr_ff[i] <= '0;
         sync_mask_ff  <= '0;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PORT_COUNT: port_count_ff   <= csr_chan.data[PCOUNT_W-1:0];
            CSR_PORT0_ADDR: port_addr_ff[0] <= csr_chan.data[ADDR_W-1:0];
            CSR_PORT1_ADDR: port_addr_ff[1] <= csr_chan.data[ADDR_W-1:0];
            CSR_PORT2_ADDR: port_addr_ff[2] <= csr_chan.data[ADDR_W-1:0];
            CSR_PORT3_ADDR: port_addr_ff[3] <= csr_chan.data[ADDR_W-1:0];
            CSR_SYNC_MASK:  sync_mask_ff    <= csr_chan.data[ADDR_REGS-1:0];
            CSR_TIMEOUT:    timeout_ff      <= csr_chan.data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = cmd.idle && !reset;
   assign take_item      = req_chan.ready && req_chan.valid;

   // sync_flag has no bearing on any verdict
   always_ff @(posedge clock) begin
      if (take_item) begin
         act_ff  <= req_chan.action;
         addr_ff <= req_chan.packet_address;
         seq_ff  <= req_chan.packet_seq;
         now_ff  <= req_chan.now_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pidx_ff  <= '0;
         found_ff <= 1'b0;
      end else if (take_item) begin
         pidx_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.advance)   pidx_ff  <= pidx_ff + 1'b1;
         if (cmd.emit_port) found_ff <= 1'b1;
      end
   end

   assign active = (port_count_ff > PORTS_USED_C) ? PORTS_USED_C : port_count_ff;
   assign psel   = pidx_ff[PIDX_W-1:0];
   assign sidx   = pidx_ff[SIDX_W-1:0];

   assign cur_seq  = stored_seq_ff[sidx];
   assign next_seq = (cur_seq == SEQ_MAX) ? SEQ_W'(1) : cur_seq + 1'b1;
   assign seq_diff = cur_seq - seq_ff;
   assign new_seq  = (seq_ff != '0) ? seq_ff : cur_seq + 1'b1;

   // borrow set when now is below the stored tick: no resync then
   assign tick_diff = {1'b0, now_ff} - {1'b0, last_tick_ff[sidx]};
   assign timed_out = !tick_diff[TICK_W] && (tick_diff[TICK_W-1:0] > TICK_W'(timeout_ff));

   always_comb begin
      if (seq_ff == '0 || cur_seq == '0)            pkt_verdict = V_INIT;
      else if (seq_ff == next_seq)                  pkt_verdict = V_INORDER;
      else if (seq_ff > cur_seq || seq_diff >= SEQ_HALF) pkt_verdict = V_SKIP;
      else if (timed_out)                           pkt_verdict = V_RESYNC;
      else                                          pkt_verdict = V_DROP;
   end

   assign cur_verdict = act_ff ? V_SYNC : pkt_verdict;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS_USED; i++) begin
            stored_seq_ff[i] <= '0;
            last_tick_ff[i]  <= '0;
         end
      end else if (cmd.emit_port && !act_ff && pkt_verdict != V_DROP) begin
         stored_seq_ff[sidx] <= new_seq;
         last_tick_ff[sidx]  <= now_ff;
      end
   end

   assign load = cmd.emit_port || cmd.emit_noport;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_port_ff    <= cmd.emit_noport ? '0 : psel;
         rsp_verdict_ff <= cmd.emit_noport ? V_NOPORT : cur_verdict;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.port    = rsp_port_ff;
   assign rsp_chan.verdict = rsp_verdict_ff;
   assign rsp_chan.deliver = 1'b0;

   assign status.req_valid   = req_chan.valid;
   assign status.scan_end    = pidx_ff >= active;
   assign status.hit         = act_ff ? sync_mask_ff[psel] : (port_addr_ff[psel] == addr_ff);
   assign status.need_noport = !found_ff && !act_ff;
   assign status.slot_free   = !rsp_valid_ff || rsp_chan.ready;

   `DUSF_ASSERT_NEVER(a_no_overwrite, clock, reset,
      load && rsp_valid_ff && !rsp_chan.ready, "result register overwritten")
   `DUSF_ASSERT(a_emit_on_hit, clock, reset,
      cmd.emit_port |-> (status.hit && !status.scan_end), "verdict for a port not hit")
   `DUSF_ASSERT(a_found_set, clock, reset,
      cmd.emit_port |=> found_ff, "match not recorded")
   `DUSF_ASSERT(a_scan_restart, clock, reset,
      take_item |=> (pidx_ff == '0 && !found_ff), "scan did not restart on new request")

endmodule

// ===== rtl/dmx_universe_sequence_filter_unit.sv =====
// Channel   Dir  Handshake     Contents
// req_chan  in   valid/ready   action, packet_address, packet_seq, sync_flag, now_tick
// rsp_chan  out  valid/ready   port, verdict, deliver
// csr_chan  in   valid/ready   register index, write data
//
// A request is handled in steps: one to accept, one per active port
// (P = min(port_count, 4)), one to close the scan. The controller scans
// one port per cycle while no hit port waits for the result register.
// Reset is synchronous, active high; per-port sequence state clears at once.
// A full result register stalls the scan at the next port that needs a slot.
// The result register decouples the output: results wait there while the
// block goes on to accept the next request.
module dmx_universe_sequence_filter_unit import dusf_pkg::*; (
   input logic        clock,
   input logic        reset,
   dusf_req_if.sink   req_chan,
   dusf_rsp_if.source rsp_chan,
   dusf_csr_if.sink   csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: idle/scan, one step per port
   dusf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // config, request latch, per-port state, classifier, result register
   dusf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// ===== test/tb_dmx_universe_sequence_filter_unit.sv =====
`timescale 1ns / 1ps

module tb_dmx_universe_sequence_filter_unit;
   import dusf_pkg::*;

   // Register index with no register behind it; writes there change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   // A full scan of all ports, plus the result register, with margin.
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic [PIDX_W-1:0] port;
      verdict_type       verdict;
   } verdict_entry_type;

   logic clock;
   logic reset;

   dusf_req_if req_chan ();
   dusf_rsp_if rsp_chan ();
   dusf_csr_if csr_chan ();

   dmx_universe_sequence_filter_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor copy of the registers.
   logic [PCOUNT_W-1:0] cfg_port_count;
   logic [ADDR_W-1:0]   cfg_addr [ADDR_REGS];
   logic [3:0]          cfg_sync_mask;
   logic [TMO_W-1:0]    cfg_timeout;

   // Predictor copy of the per-port sequence state.
   logic [SEQ_W-1:0]    port_seq  [PORTS_USED];
   logic [TICK_W-1:0]   port_tick [PORTS_USED];

   verdict_entry_type   pending_verdicts [$];
   int                  error_count = 0;
   bit                  req_up = 1'b0;  // req valid currently held high
   bit                  steady = 1'b0;  // no idling on either side
   logic [TICK_W-1:0]   cur_tick;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Verdict predictor
   // -------------------------------------------------------------------------

   function automatic void reset_predictor();
      cfg_port_count = '0;
      cfg_sync_mask  = '0;
      cfg_timeout    = TIMEOUT_RESET;
      for (int i = 0; i < ADDR_REGS; i++) cfg_addr[i] = '0;
      for (int i = 0; i < PORTS_USED; i++) begin
         port_seq[i]  = '0;
         port_tick[i] = '0;
      end
   endfunction

   function automatic void apply_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_PORT_COUNT: cfg_port_count = val[PCOUNT_W-1:0];
         CSR_PORT0_ADDR: cfg_addr[0] = val[ADDR_W-1:0];
         CSR_PORT1_ADDR: cfg_addr[1] = val[ADDR_W-1:0];
         CSR_PORT2_ADDR: cfg_addr[2] = val[ADDR_W-1:0];
         CSR_PORT3_ADDR: cfg_addr[3] = val[ADDR_W-1:0];
         CSR_SYNC_MASK:  cfg_sync_mask = val[3:0];
         CSR_TIMEOUT:    cfg_timeout = val[TMO_W-1:0];
         default: ;
      endcase
   endfunction

   // port_count above the port total clamps to the total.
   function automatic int unsigned active_port_total();
      int unsigned n;
      n = cfg_port_count;
      if (n > PORTS_USED) n = PORTS_USED;
      return n;
   endfunction

   // Classify one packet against one port; accepted verdicts update state.
   function automatic verdict_type classify_packet(input int unsigned p,
                                                   input logic [SEQ_W-1:0] seq,
                                                   input logic [TICK_W-1:0] now);
      logic [SEQ_W-1:0] s;
      logic [SEQ_W-1:0] nxt;
      logic [SEQ_W-1:0] gap;
      verdict_type      v;
      s   = port_seq[p];
      nxt = (s == SEQ_MAX) ? SEQ_W'(1) : SEQ_W'(s + 1'b1);
      gap = s - seq;
      if (seq == '0 || s == '0)
         v = V_INIT;
      else if (seq == nxt)
         v = V_INORDER;
      else if (seq > s || gap >= SEQ_HALF)
         v = V_SKIP;
      else if (port_tick[p] < now && TICK_W'(now - port_tick[p]) > TICK_W'(cfg_timeout))
         v = V_RESYNC;  // no wrap handling: an older now_tick never resyncs
      else
         return V_DROP;
      // sequence 0 still counts up, 255 + 1 lands on 0
      port_seq[p]  = (seq != '0) ? seq : SEQ_W'(s + 1'b1);
      port_tick[p] = now;
      return v;
   endfunction

   function automatic void predict_request(input logic act,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [TICK_W-1:0] now);
      int unsigned       n;
      int                hits;
      verdict_entry_type e;
      n    = active_port_total();
      hits = 0;
      if (act) begin
         // sync fan-out; address, sequence and tick play no part
         for (int unsigned p = 0; p < n; p++) begin
            if (cfg_sync_mask[p]) begin
               e.port    = PIDX_W'(p);
               e.verdict = V_SYNC;
               pending_verdicts.push_back(e);
            end
         end
      end else begin
         // every matching port gets its own verdict, in port order
         for (int unsigned p = 0; p < n; p++) begin
            if (cfg_addr[p] == addr) begin
               e.port    = PIDX_W'(p);
               e.verdict = classify_packet(p, seq, now);
               pending_verdicts.push_back(e);
               hits++;
            end
         end
         if (hits == 0) begin
            e.port    = '0;
            e.verdict = V_NOPORT;
            pending_verdicts.push_back(e);
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // One request; prediction is made at the accepting edge. Valid stays up
   // across back-to-back requests, and drops only for an idle gap.
   task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr,
                               input logic [SEQ_W-1:0] seq, input logic smode,
                               input logic [TICK_W-1:0] now);
      req_chan.action         <= act;
      req_chan.packet_address <= addr;
      req_chan.packet_seq     <= seq;
      req_chan.sync_flag      <= smode;
      req_chan.now_tick       <= now;
      req_chan.valid          <= 1'b1;
      req_up = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      predict_request(act, addr, seq, now);
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      apply_csr_write(idx, val);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sender stops until every predicted verdict has come back.
   task automatic hold_until_drained();
      if (req_up) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
         @(posedge clock);
      end
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // A sync with no enabled port leaves no trace, so after the last verdict
   // give the scan time to finish before touching registers.
   task automatic settle_block();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin : rsp_monitor
      verdict_entry_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result port %0d verdict %0d",
                                         rsp_chan.port, rsp_chan.verdict));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_chan.port !== want.port)
                  report_mismatch($sformatf("port %0d, predicted %0d",
                                            rsp_chan.port, want.port));
               if (rsp_chan.verdict !== want.verdict)
                  report_mismatch($sformatf("verdict %0d on port %0d, predicted %0d",
                                            rsp_chan.verdict, want.port, want.verdict));
               if (rsp_chan.deliver !== 1'b0)
                  report_mismatch($sformatf("deliver %b on port %0d, predicted 0",
                                            rsp_chan.deliver, want.port));
            end
         end
         // about a quarter of cycles stalled, none in steady stretches
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 25);
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset state: no active port, so any packet is unmatched and sync is silent.
   task automatic test_reset_defaults();
      send_request(1'b0, '0, '0, 1'b0, 32'd0);
      send_request(1'b1, '0, '0, 1'b0, 32'd0);
   endtask

   // Walk the classification on hand-picked sequences; timeout still at reset.
   task automatic test_directed_sequences();
      settle_block();
      write_csr(CSR_PORT_COUNT, 16'd4);
      write_csr(CSR_PORT0_ADDR, 16'h0000);
      write_csr(CSR_PORT1_ADDR, 16'h7FFF);
      write_csr(CSR_PORT2_ADDR, 16'h1234);
      write_csr(CSR_PORT3_ADDR, 16'h1234);   // duplicate of port 2
      write_csr(CSR_SYNC_MASK,  16'h000A);
      send_request(1'b0, 15'h0000, 8'd0,   1'b0, 32'd100);        // init, seq 0
      send_request(1'b0, 15'h0000, 8'd2,   1'b1, 32'd110);        // in order
      send_request(1'b0, 15'h0000, 8'd255, 1'b0, 32'd120);        // skipped ahead
      send_request(1'b0, 15'h0000, 8'd1,   1'b0, 32'd130);        // 255 wraps to 1
      send_request(1'b0, 15'h0000, 8'd1,   1'b0, 32'd140);        // repeat, dropped
      send_request(1'b0, 15'h0000, 8'd1,   1'b0, 32'd1200);       // past timeout
      send_request(1'b0, 15'h0000, 8'd0,   1'b1, 32'hFFFF_FFFF);  // init at max tick
      send_request(1'b0, 15'h0000, 8'd1,   1'b0, 32'd5);          // tick wrapped
      hold_until_drained();
      send_request(1'b0, 15'h7FFF, 8'd200, 1'b0, 32'd0);          // stored zero
      send_request(1'b0, 15'h7FFF, 8'd60,  1'b0, 32'd10);         // 140 behind
      send_request(1'b0, 15'h7FFF, 8'd255, 1'b0, 32'd30);
      send_request(1'b0, 15'h7FFF, 8'd128, 1'b0, 32'd40);         // 127 behind
      send_request(1'b0, 15'h7FFF, 8'd127, 1'b0, 32'd50);         // 128 behind
      send_request(1'b0, 15'h1234, 8'd7,   1'b1, 32'd60);         // two ports hit
      send_request(1'b0, 15'h4321, 8'd9,   1'b0, 32'd65);         // no port
      send_request(1'b1, 15'h7FFF, 8'hFF,  1'b1, 32'hFFFF_FFFF);  // sync, ports 1 and 3
      send_request(1'b0, 15'h7FFF, 8'd0,   1'b0, 32'd66);
      send_request(1'b0, 15'h7FFF, 8'd255, 1'b0, 32'd70);
      send_request(1'b0, 15'h7FFF, 8'd0,   1'b0, 32'd80);         // 255 + 1 stores 0
      send_request(1'b0, 15'h7FFF, 8'd9,   1'b0, 32'd90);
   endtask

   // Timeout extremes at the resync boundary.
   task automatic test_timeout_edges();
      settle_block();
      write_csr(CSR_TIMEOUT, 16'd0);
      send_request(1'b0, 15'h0000, 8'd50, 1'b0, 32'd1000);
      send_request(1'b0, 15'h0000, 8'd40, 1'b0, 32'd1000);        // same tick, dropped
      send_request(1'b0, 15'h0000, 8'd40, 1'b0, 32'd1001);        // one tick later
      settle_block();
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      send_request(1'b0, 15'h0000, 8'd30, 1'b0, 32'd1001 + 32'd65535);
      send_request(1'b0, 15'h0000, 8'd30, 1'b0, 32'd1001 + 32'd65536);
   endtask

   task automatic configure_phase(input int unsigned count, input int unsigned tmo,
                                  input logic [3:0] mask);
      logic [ADDR_W-1:0] a [ADDR_REGS];
      for (int i = 0; i < ADDR_REGS; i++)
         a[i] = (i > 0 && $urandom_range(0, 99) < 30) ? a[0] : ADDR_W'($urandom);
      // unused upper data bits carry junk
      write_csr(CSR_PORT_COUNT, {13'($urandom), PCOUNT_W'(count)});
      write_csr(CSR_PORT0_ADDR, {1'($urandom), a[0]});
      write_csr(CSR_PORT1_ADDR, {1'($urandom), a[1]});
      write_csr(CSR_PORT2_ADDR, {1'($urandom), a[2]});
      write_csr(CSR_PORT3_ADDR, {1'($urandom), a[3]});
      write_csr(CSR_SYNC_MASK,  {12'($urandom), mask});
      write_csr(CSR_TIMEOUT,    TMO_W'(tmo));
   endtask

   // Mostly well-formed streams per port, with sync events and stray packets.
   task automatic run_random_phase(input int items);
      int unsigned      n;
      int unsigned      p;
      int unsigned      r;
      logic [SEQ_W-1:0] s;
      logic [SEQ_W-1:0] seq;
      for (int i = 0; i < items; i++) begin
         n = active_port_total();
         r = $urandom_range(0, 99);
         cur_tick = cur_tick + $urandom_range(0, int'(cfg_timeout) * 3 / 2 + 2);
         if (r < 3) hold_until_drained();
         if (r < 12) begin
            send_request(1'b1, ADDR_W'($urandom), SEQ_W'($urandom), 1'($urandom),
                         TICK_W'($urandom));
         end else if (r < 22 || n == 0) begin
            send_request(1'b0, ADDR_W'($urandom), SEQ_W'($urandom), 1'($urandom), cur_tick);
         end else begin
            p = $urandom_range(0, n - 1);
            s = port_seq[p];
            r = $urandom_range(0, 99);
            if (r < 55)
               seq = (s == SEQ_MAX) ? SEQ_W'(1) : SEQ_W'(s + 1'b1);
            else if (r < 65)
               seq = '0;
            else if (r < 75)
               seq = s + SEQ_W'($urandom_range(2, 127));
            else
               seq = s - SEQ_W'($urandom_range(0, 20));  // usually resync or drop, by tick
            send_request(1'b0, cfg_addr[p], seq, 1'($urandom), cur_tick);
         end
      end
   endtask

   task automatic test_random_traffic();
      int unsigned counts [7] = '{4, 1, 7, 2, 0, 3, 6};
      int unsigned tmos   [7] = '{1000, 0, 65535, 50, 300, 0, 20};
      logic [3:0]  mask;
      for (int ph = 0; ph < 7; ph++) begin
         settle_block();
         mask = (ph == 0) ? 4'hF : (ph == 1) ? 4'h0 : 4'($urandom);
         configure_phase(counts[ph], (ph == 6) ? $urandom_range(1, 2000) : tmos[ph], mask);
         if (ph == 0) write_csr(CSR_UNUSED, 16'($urandom));
         cur_tick = $urandom;
         steady = (ph == 3);
         run_random_phase((counts[ph] == 0) ? 10 : 40);
         steady = 1'b0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequencing
   // -------------------------------------------------------------------------

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.action         <= 1'b0;
      req_chan.packet_address <= '0;
      req_chan.packet_seq     <= '0;
      req_chan.sync_flag      <= 1'b0;
      req_chan.now_tick       <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.data           <= '0;
      reset_predictor();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_sequences();
      test_timeout_edges();
      test_random_traffic();

      settle_block();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dusf_pkg.sv
rtl/dusf_req_if.sv
rtl/dusf_rsp_if.sv
rtl/dusf_csr_if.sv
rtl/dusf_ctrl.sv
rtl/dusf_datapath.sv
rtl/dmx_universe_sequence_filter_unit.sv
test/tb_dmx_universe_sequence_filter_unit.sv
